/* rtl/core/wglob_pkg.sv */
package wglob_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int REG_BYTES   = 16;
    localparam int POS_W       = $clog2(PATTERN_MAX + 1);
    localparam int LEN_FIELD_W = 5;
    localparam int DATA_W      = 64;
    localparam int ADDR_W      = 5;
    localparam int REG_SEL_W   = 2;
    localparam int LEN_LIMIT   = (REG_BYTES < PATTERN_MAX) ? REG_BYTES : PATTERN_MAX;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_ANY  = 8'h3F;

    typedef enum logic [REG_SEL_W-1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_PAT_LEN  = 2'd2,
        REG_NONE     = 2'd3
    } wglob_reg_t;

    // Signals handed from one position cell to the next one up.
    typedef struct packed {
        logic closure;
        logic advance;
    } wglob_link_t;

endpackage

/* rtl/core/wildcard_glob_matcher.sv */
// Streaming glob matcher. Text arrives one byte per word on the s_ channel and a word with
// s_end_of_text set closes the text: it yields one m_ word carrying the verdict and puts the
// matcher back at the start of the pattern. Text words yield nothing. The pattern (up to 16
// bytes, '*' for any run, '?' for any single byte, anything else literal) and its length sit
// in APB registers at 0x00, 0x08 and 0x10; the user must write them only while no verdict is
// pending, which the block does not enforce. It takes one word per clock cycle while m_ready
// is high or no verdict waits; position cells update the whole active position vector
// together, with star closure rippling up the row. The verdict sits in an output register and
// holds the input off until taken, a new word going in the same cycle as the verdict is taken.
module wildcard_glob_matcher (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wglob_pkg::ADDR_W-1:0]     paddr,
    input  logic [wglob_pkg::DATA_W-1:0]     pwdata,
    output logic [wglob_pkg::DATA_W-1:0]     prdata,
    output logic                             pready,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_text_byte,
    input  logic                             s_end_of_text,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_matched
);
    import wglob_pkg::*;

    logic [DATA_W-1:0]      pat_low_reg;
    logic [DATA_W-1:0]      pat_high_reg;
    logic [LEN_FIELD_W-1:0] pat_len_reg;
    logic                   m_valid_reg;
    logic                   m_matched_reg;

    wglob_reg_t             reg_sel;
    logic                   cfg_write;
    logic [POS_W-1:0]       len_eff;
    logic [8*REG_BYTES-1:0] pat_all;
    logic                   accept;
    logic                   step_text;
    logic                   step_end;
    logic [PATTERN_MAX:0]   closed;
    wglob_link_t            links [PATTERN_MAX+1:0];

    assign pready    = 1'b1;
    assign reg_sel   = wglob_reg_t'(paddr[ADDR_W-1:ADDR_W-REG_SEL_W]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_PAT_LOW:  pat_low_reg  <= pwdata;
                REG_PAT_HIGH: pat_high_reg <= pwdata;
                REG_PAT_LEN:  pat_len_reg  <= pwdata[LEN_FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_PAT_LOW:  prdata = pat_low_reg;
            REG_PAT_HIGH: prdata = pat_high_reg;
            REG_PAT_LEN:  prdata = {{(DATA_W-LEN_FIELD_W){1'b0}}, pat_len_reg};
            default:      prdata = '0;
        endcase
    end

    // Lengths beyond what the registers hold saturate.
    always_comb begin
        if (int'(pat_len_reg) > LEN_LIMIT) begin
            len_eff = POS_W'(LEN_LIMIT);
        end else begin
            len_eff = POS_W'(pat_len_reg);
        end
    end

    assign pat_all   = (8*REG_BYTES)'({pat_high_reg, pat_low_reg});
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign step_text = accept && !s_end_of_text;
    assign step_end  = accept && s_end_of_text;

    assign links[0] = '0;

    for (genvar p = 0; p <= PATTERN_MAX; p++) begin : g_cell
        logic [7:0] pat_char;
        if (p < REG_BYTES) begin : g_char
            assign pat_char = pat_all[8*p +: 8];
        end else begin : g_nochar
            assign pat_char = 8'h00;
        end

        wglob_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .is_start  (p == 0),
            .pos_live  (POS_W'(p) <= len_eff),
            .pos_used  (POS_W'(p) < len_eff),
            .pat_char  (pat_char),
            .text_byte (s_text_byte),
            .step_text (step_text),
            .step_end  (step_end),
            .link_in   (links[p]),
            .link_out  (links[p+1]),
            .closed    (closed[p])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_end) begin
            m_matched_reg <= closed[len_eff];
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_matched = m_matched_reg;

endmodule

/* rtl/core/wglob_cell.sv */
module wglob_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  is_start,
    input  logic                  pos_live,
    input  logic                  pos_used,
    input  logic [7:0]            pat_char,
    input  logic [7:0]            text_byte,
    input  logic                  step_text,
    input  logic                  step_end,
    input  wglob_pkg::wglob_link_t link_in,
    output wglob_pkg::wglob_link_t link_out,
    output logic                  closed
);
    import wglob_pkg::*;

    logic active_reg;
    logic active_next;
    logic is_star;
    logic hit;
    logic stay;

    assign is_star = (pat_char == CH_STAR);
    assign hit     = pos_used && !is_star && ((pat_char == CH_ANY) || (pat_char == text_byte));

    // A position reads as active if it holds the bit within the live length or a star below hands it up.
    assign closed = (active_reg && pos_live) || link_in.closure;
    assign stay   = closed && is_star && pos_used;

    assign link_out.closure = stay;
    assign link_out.advance = closed && hit;

    always_comb begin
        priority if (step_end) begin
            active_next = is_start;
        end else if (step_text) begin
            active_next = stay || link_in.advance;
        end else begin
            active_next = active_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= is_start;
        end else begin
            active_reg <= active_next;
        end
    end

endmodule

/* rtl/core/wglob_checker.sv */
module wglob_checker (
    input logic aclk,
    input logic aresetn,
    input logic pready,
    input logic s_valid,
    input logic s_ready,
    input logic s_end_of_text,
    input logic m_valid,
    input logic m_ready,
    input logic m_matched
);

    // A verdict only appears after an end-of-text word was taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_end_of_text))
        else $error("verdict without end of text");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_end_of_text) |=> m_valid)
        else $error("end of text gave no verdict");

    // With the output side empty, the input side must never stall.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_matched)))
        else $error("stalled verdict changed");

    assert property (@(posedge aclk) pready)
        else $error("config port not ready");

endmodule

bind wildcard_glob_matcher wglob_checker u_wglob_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .pready        (pready),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_end_of_text (s_end_of_text),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_matched     (m_matched)
);

/* verif/wildcard_glob_matcher_tb.sv */
`timescale 1ns / 100ps

module wildcard_glob_matcher_tb;
    import wglob_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct {
        logic matched;
        int   text_no;
    } verdict_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic [7:0]          s_text_byte;
    logic                s_end_of_text;
    logic                m_valid;
    logic                m_ready;
    logic                m_matched;

    // Shadow copy of the pattern registers and of the active position vector.
    logic [63:0]         pat_lo_q;
    logic [63:0]         pat_hi_q;
    logic [4:0]          pat_len_q;
    logic [PATTERN_MAX:0] live_pos;

    verdict_t            verdict_q[$];
    verdict_t            want;
    int                  texts_closed;
    int                  words_sent;
    int                  err_count;
    int                  cycle_no;
    int                  idle_odds;
    int                  hold_req;
    int                  hold_left;
    int                  stall_left;
    logic [7:0]          rand_pat[16];
    logic [7:0]          txt[$];

    wildcard_glob_matcher uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_matched     (m_matched)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no == CYCLE_LIMIT) begin
            $display("wildcard_glob_matcher_tb: errors");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        if (err_count < 50) $display("MISMATCH cycle %0d: %s", cycle_no, msg);
        err_count++;
    endtask

    function automatic int used_len();
        int n;
        n = int'(pat_len_q);
        if (n > REG_BYTES) n = REG_BYTES;
        if (n > PATTERN_MAX) n = PATTERN_MAX;
        return n;
    endfunction

    function automatic logic [7:0] pat_char(input int i);
        logic [63:0] w;
        w = (i < 8) ? pat_lo_q : pat_hi_q;
        return w[(i % 8) * 8 +: 8];
    endfunction

    // Advances the shadow position vector by one word; an end of text yields the verdict.
    task automatic advance_glob(input logic [7:0] b, input logic eot);
        int n;
        logic [PATTERN_MAX:0] cur;
        logic [PATTERN_MAX:0] nxt;
        n = used_len();
        cur = '0;
        nxt = '0;
        for (int p = 0; p <= n; p++) cur[p] = live_pos[p];
        for (int p = 0; p < n; p++)
            if (cur[p] && pat_char(p) == CH_STAR) cur[p + 1] = 1'b1;
        if (eot) begin
            verdict_q.push_back('{matched: cur[n], text_no: texts_closed});
            texts_closed++;
            live_pos = (PATTERN_MAX+1)'(1);
        end else begin
            for (int p = 0; p < n; p++) begin
                if (cur[p]) begin
                    if (pat_char(p) == CH_STAR) nxt[p] = 1'b1;
                    else if (pat_char(p) == CH_ANY || pat_char(p) == b) nxt[p + 1] = 1'b1;
                end
            end
            live_pos = nxt;
        end
    endtask

    task automatic write_reg(input wglob_reg_t r, input logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_PAT_LOW: begin
                pat_lo_q = v;
            end
            REG_PAT_HIGH: begin
                pat_hi_q = v;
            end
            REG_PAT_LEN: begin
                pat_len_q = v[4:0];
            end
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    task automatic set_pattern(input string s, input int len);
        logic [63:0] lo;
        logic [63:0] hi;
        lo = '0;
        hi = '0;
        for (int i = 0; i < s.len() && i < 16; i++) begin
            if (i < 8) lo[i * 8 +: 8] = s[i];
            else hi[(i - 8) * 8 +: 8] = s[i];
        end
        write_reg(REG_PAT_LOW, lo);
        write_reg(REG_PAT_HIGH, hi);
        write_reg(REG_PAT_LEN, 64'(len));
    endtask

    // Offers one word and holds it until the block takes it.
    task automatic send_word(input logic [7:0] b, input logic eot);
        int gap;
        s_valid       <= 1'b1;
        s_text_byte   <= b;
        s_end_of_text <= eot;
        do @(posedge aclk); while (!s_ready);
        advance_glob(b, eot);
        words_sent++;
        if (idle_odds > 0 && $urandom_range(0, idle_odds) == 0) begin
            gap = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
        send_word(8'($urandom), 1'b1);
    endtask

    // The sender stops until every verdict is in, then lets the block go quiet.
    task automatic drain_verdicts();
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                flag_mismatch($sformatf("verdict %0b with none pending", m_matched));
            end else begin
                want = verdict_q.pop_front();
                if (m_matched !== want.matched)
                    flag_mismatch($sformatf("text %0d: matched %0b, predicted %0b",
                                            want.text_no, m_matched, want.matched));
            end
        end
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_odds > 0 && $urandom_range(0, idle_odds) == 0) begin
            stall_left = $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic [7:0] pick_pat_char();
        case ($urandom_range(0, 7))
            0, 1: return "a";
            2: return "b";
            3, 4: return CH_STAR;
            5: return CH_ANY;
            6: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_text_char();
        case ($urandom_range(0, 4))
            0, 1: return "a";
            2: return "b";
            3: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    // Builds a text that mostly fits the current pattern, sometimes damaged or pure noise.
    task automatic build_text();
        int n;
        n = used_len();
        txt.delete();
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(0, 12)) txt.push_back(8'($urandom));
        end else begin
            for (int i = 0; i < n; i++) begin
                if (pat_char(i) == CH_STAR)
                    repeat ($urandom_range(0, 3)) txt.push_back(pick_text_char());
                else if (pat_char(i) == CH_ANY)
                    txt.push_back(pick_text_char());
                else
                    txt.push_back(pat_char(i));
            end
            if ($urandom_range(0, 3) == 0) begin
                if (txt.size() > 0 && $urandom_range(0, 1) == 0)
                    txt[$urandom_range(0, txt.size() - 1)] = pick_text_char();
                else if (txt.size() > 0)
                    void'(txt.pop_back());
                else
                    txt.push_back(pick_text_char());
            end
        end
    endtask

    task automatic test_empty_pattern();
        set_pattern("", 0);
        send_word(8'($urandom), 1'b1);
        send_text("x");
        drain_verdicts();
    endtask

    task automatic test_wildcards();
        set_pattern("*", 1);
        send_word(8'h00, 1'b1);
        send_text("abc");
        drain_verdicts();
        // A question mark still waiting at the end of the text must fail.
        set_pattern("?", 1);
        send_word(8'hFF, 1'b1);
        send_text("q");
        drain_verdicts();
        set_pattern("a**b", 4);
        send_text("ab");
        drain_verdicts();
        set_pattern("a?c", 3);
        send_text("abc");
        drain_verdicts();
    endtask

    task automatic test_zero_bytes();
        // Length past the string pads the pattern with a zero literal.
        set_pattern("z", 2);
        send_word("z", 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b1);
        drain_verdicts();
    endtask

    task automatic test_full_length();
        // Fifteen stars then an all-ones byte, with the length field at its top value.
        write_reg(REG_PAT_LOW, {8{CH_STAR}});
        write_reg(REG_PAT_HIGH, {8'hFF, {7{CH_STAR}}});
        write_reg(REG_PAT_LEN, 64'h1F);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);
        drain_verdicts();
    endtask

    task automatic test_pattern_swap_mid_text();
        set_pattern("ab*c", 4);
        send_word("a", 1'b0);
        send_word("b", 1'b0);
        drain_verdicts();
        set_pattern("a?x", 3);
        send_word("x", 1'b0);
        send_word(8'h00, 1'b1);
        drain_verdicts();
    endtask

    task automatic test_output_backpressure();
        idle_odds = 3;
        set_pattern("a*", 2);
        hold_req = 80;
        repeat (25) begin
            send_word("a", 1'b0);
            send_word(8'($urandom), 1'b1);
        end
        drain_verdicts();
    endtask

    task automatic test_random_texts(input int target, input bit allow_idle);
        int stop_at;
        int n_texts;
        logic [63:0] lo;
        logic [63:0] hi;
        stop_at = words_sent + target;
        while (words_sent < stop_at) begin
            if (!allow_idle) idle_odds = 0;
            else case ($urandom_range(0, 2))
                0: idle_odds = 0;
                1: idle_odds = 3;
                default: idle_odds = 8;
            endcase
            for (int i = 0; i < 16; i++) rand_pat[i] = pick_pat_char();
            for (int i = 0; i < 8; i++) begin
                lo[i * 8 +: 8] = rand_pat[i];
                hi[i * 8 +: 8] = rand_pat[i + 8];
            end
            if ($urandom_range(0, 9) == 0) begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
            end
            write_reg(REG_PAT_LOW, lo);
            write_reg(REG_PAT_HIGH, hi);
            if ($urandom_range(0, 9) == 0)
                write_reg(REG_PAT_LEN, {$urandom, $urandom});
            else
                write_reg(REG_PAT_LEN, 64'($urandom_range(0, 16)));
            n_texts = $urandom_range(1, 8);
            for (int t = 0; t < n_texts; t++) begin
                build_text();
                foreach (txt[i]) send_word(txt[i], 1'b0);
                // Now and then a phase ends mid-text, so the next pattern takes over.
                if (t < n_texts - 1 || $urandom_range(0, 4) != 0)
                    send_word(8'($urandom), 1'b1);
            end
            drain_verdicts();
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_valid       <= 1'b0;
        s_text_byte   <= 8'h00;
        s_end_of_text <= 1'b0;
        m_ready       <= 1'b0;
        pat_lo_q     = '0;
        pat_hi_q     = '0;
        pat_len_q    = '0;
        live_pos     = (PATTERN_MAX+1)'(1);
        texts_closed = 0;
        words_sent   = 0;
        err_count    = 0;
        cycle_no     = 0;
        idle_odds    = 0;
        hold_req     = 0;
        hold_left    = 0;
        stall_left   = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_pattern();
        test_wildcards();
        test_zero_bytes();
        test_full_length();
        test_pattern_swap_mid_text();
        test_output_backpressure();
        test_random_texts(1300, 1'b1);
        test_random_texts(200, 1'b0);

        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("wildcard_glob_matcher_tb: clean");
        end else begin
            $display("wildcard_glob_matcher_tb: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/wglob_pkg.sv
rtl/core/wglob_cell.sv
rtl/core/wildcard_glob_matcher.sv
rtl/core/wglob_checker.sv
verif/wildcard_glob_matcher_tb.sv
